>>> src/lrpw_pkg.sv
// Shared types and constants for the line rasterizer pixel writer.
package lrpw_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned DATA_BITS      = 32;
  localparam int unsigned COLOUR_BITS    = 32;
  localparam int unsigned BCNT_BITS      = 3;
  localparam int unsigned PITCH_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned MAX_BYTES      = 4;

  // request kind carried on the input tuser
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_ROW_PITCH       = 2'd1,
    CFG_FRAME_BASE      = 2'd2,
    CFG_BIG_ENDIAN      = 2'd3
  } cfg_idx_e;

  localparam logic [BCNT_BITS-1:0]  BPP_RESET   = 3'd4;
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = 16'd4096;
  localparam logic [ADDR_BITS-1:0]  BASE_RESET  = '0;

  // stepper status toward the top level
  typedef struct packed {
    logic active;  // a line is being drawn
    logic last;    // current pixel is the final one
  } step_ctl_t;

endpackage

>>> src/line_rasterizer_pixel_writer.sv
// Top level of the Bresenham line rasterizer with framebuffer pixel writes.
//
// Input stream (s_axis): tuser selects the request kind, start a line or
// advance one pixel; tdata carries both endpoints and the colour. A start
// request sets up the line and produces no output. Each advance request on an
// active line produces one framebuffer write on the output stream (m_axis):
// byte address, lane-ordered data, byte count and pixel coordinates, with
// tlast on the final pixel. An advance with no active line is consumed and
// produces nothing.
// A write appears on m_axis in the cycle after its advance request is taken.
// Throughput: one request per cycle unless the output register is stalled;
// the Bresenham step is one add and compare on the line state, the address
// two multiplies and adds into the output register.
// Stall: the output register holds its write while m_axis_tready is low; a new
// request is taken whenever the output register is empty or being drained in
// the same cycle.
// Reset: no line active, output empty, configuration at 4 bytes per pixel,
// row pitch 4096, base 0, little-endian lanes.
// Configuration writes go through cfg_we_i / cfg_index_i / cfg_data_i and take
// effect at the next edge; write them only while the block is idle.
module line_rasterizer_pixel_writer #(
  parameter int unsigned COORD_BITS = lrpw_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_RAW  = 4 * COORD_BITS + lrpw_pkg::COLOUR_BITS,
  localparam int unsigned IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = lrpw_pkg::ADDR_BITS + lrpw_pkg::DATA_BITS +
                                    lrpw_pkg::BCNT_BITS + 2 * COORD_BITS,
  localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [lrpw_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [lrpw_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low to high: x_start, y_start, x_end, y_end, colour, zero fill
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // tuser: operation
  input  logic                                s_axis_tuser,
  // pixel write stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low to high: pixel_address, write_data, byte_count, pixel_x,
  // pixel_y, zero fill
  output logic [OUT_W-1:0]                    m_axis_tdata,
  // tlast: last
  output logic                                m_axis_tlast
);

  localparam int unsigned CB = COORD_BITS;

  // configuration registers
  logic [lrpw_pkg::BCNT_BITS-1:0]  bpp_q;
  logic [lrpw_pkg::PITCH_BITS-1:0] pitch_q;
  logic [lrpw_pkg::ADDR_BITS-1:0]  base_q;
  logic                            be_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= lrpw_pkg::BPP_RESET;
      pitch_q <= lrpw_pkg::PITCH_RESET;
      base_q  <= lrpw_pkg::BASE_RESET;
      be_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (lrpw_pkg::cfg_idx_e'(cfg_index_i))
        lrpw_pkg::CFG_BYTES_PER_PIXEL: bpp_q   <= cfg_data_i[lrpw_pkg::BCNT_BITS-1:0];
        lrpw_pkg::CFG_ROW_PITCH:       pitch_q <= cfg_data_i[lrpw_pkg::PITCH_BITS-1:0];
        lrpw_pkg::CFG_FRAME_BASE:      base_q  <= cfg_data_i[lrpw_pkg::ADDR_BITS-1:0];
        lrpw_pkg::CFG_BIG_ENDIAN:      be_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request unpack
  logic                             in_acc;
  lrpw_pkg::op_e                    in_op;
  logic [CB-1:0]                    in_x0, in_y0, in_x1, in_y1;
  logic [lrpw_pkg::COLOUR_BITS-1:0] in_colour;

  assign in_op     = lrpw_pkg::op_e'(s_axis_tuser);
  assign in_x0     = s_axis_tdata[0*CB +: CB];
  assign in_y0     = s_axis_tdata[1*CB +: CB];
  assign in_x1     = s_axis_tdata[2*CB +: CB];
  assign in_y1     = s_axis_tdata[3*CB +: CB];
  assign in_colour = s_axis_tdata[4*CB +: lrpw_pkg::COLOUR_BITS];

  // output register is the skid stage: take a request if it is empty or draining
  logic out_valid_q, out_valid_d;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  logic [CB-1:0]                    cur_x, cur_y;
  logic [lrpw_pkg::COLOUR_BITS-1:0] cur_colour;
  lrpw_pkg::step_ctl_t              ctl;

  lrpw_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .op_i      (in_op),
    .x_start_i (in_x0),
    .y_start_i (in_y0),
    .x_end_i   (in_x1),
    .y_end_i   (in_y1),
    .colour_i  (in_colour),
    .cur_x_o   (cur_x),
    .cur_y_o   (cur_y),
    .colour_o  (cur_colour),
    .ctl_o     (ctl)
  );

  logic [lrpw_pkg::ADDR_BITS-1:0] f_addr;
  logic [lrpw_pkg::DATA_BITS-1:0] f_data;
  logic [lrpw_pkg::BCNT_BITS-1:0] f_bcnt;

  lrpw_pixel_fmt #(.COORD_BITS(COORD_BITS)) u_fmt (
    .cur_x_i      (cur_x),
    .cur_y_i      (cur_y),
    .colour_i     (cur_colour),
    .bpp_i        (bpp_q),
    .pitch_i      (pitch_q),
    .base_i       (base_q),
    .big_endian_i (be_q),
    .addr_o       (f_addr),
    .data_o       (f_data),
    .byte_count_o (f_bcnt)
  );

  // a write is produced only by an advance on an active line
  logic emit;
  assign emit = in_acc & (in_op == lrpw_pkg::OP_ADVANCE) & ctl.active;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  logic [lrpw_pkg::ADDR_BITS-1:0] addr_q;
  logic [lrpw_pkg::DATA_BITS-1:0] data_q;
  logic [lrpw_pkg::BCNT_BITS-1:0] bcnt_q;
  logic [CB-1:0]                  px_q, py_q;
  logic                           last_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q <= f_addr;
      data_q <= f_data;
      bcnt_q <= f_bcnt;
      px_q   <= cur_x;
      py_q   <= cur_y;
      last_q <= ctl.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = OUT_W'({py_q, px_q, bcnt_q, data_q, addr_q});

  // checks
  a_skid_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while output register is stalled");

  a_start_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == lrpw_pkg::OP_START) |=> ctl.active)
    else $error("line not active after start");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ctl.last) |=> (!ctl.active && out_valid_q && m_axis_tlast))
    else $error("final pixel did not end the line");

  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (bcnt_q != '0 &&
                     bcnt_q <= lrpw_pkg::BCNT_BITS'(lrpw_pkg::MAX_BYTES)))
    else $error("byte count out of range");

endmodule

>>> src/lrpw_stepper.sv
// Bresenham line state: setup on start requests, one step per advance request.
module lrpw_stepper #(
  parameter int unsigned COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  lrpw_pkg::op_e                      op_i,
  input  logic [COORD_BITS-1:0]              x_start_i,
  input  logic [COORD_BITS-1:0]              y_start_i,
  input  logic [COORD_BITS-1:0]              x_end_i,
  input  logic [COORD_BITS-1:0]              y_end_i,
  input  logic [lrpw_pkg::COLOUR_BITS-1:0]   colour_i,
  output logic [COORD_BITS-1:0]              cur_x_o,
  output logic [COORD_BITS-1:0]              cur_y_o,
  output logic [lrpw_pkg::COLOUR_BITS-1:0]   colour_o,
  output lrpw_pkg::step_ctl_t                ctl_o
);

  localparam int unsigned DW = COORD_BITS + 2;  // decision term width
  localparam int unsigned TW = COORD_BITS + 1;  // doubled delta / pixel count

  logic [COORD_BITS-1:0]            cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [TW-1:0]                    left_q, left_d;
  logic signed [DW-1:0]             dterm_q, dterm_d;
  logic [TW-1:0]                    t2dx_q, t2dx_d, t2dy_q, t2dy_d;
  logic                             xb_q, xb_d, yb_q, yb_d, xm_q, xm_d;
  logic [lrpw_pkg::COLOUR_BITS-1:0] colour_q, colour_d;
  logic                             active_q, active_d;

  // setup terms
  logic                  s_xb, s_yb, s_xm;
  logic [COORD_BITS-1:0] s_dx, s_dy, s_major;
  logic [TW-1:0]         s_t2dx, s_t2dy, s_minor2;

  // step terms
  logic          is_last, d_pos, step_x, step_y;
  logic [TW-1:0] add_t, sub_t;

  always_comb begin
    s_xb     = x_end_i < x_start_i;
    s_yb     = y_end_i < y_start_i;
    s_dx     = s_xb ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    s_dy     = s_yb ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    s_t2dx   = {s_dx, 1'b0};
    s_t2dy   = {s_dy, 1'b0};
    s_xm     = s_dx > s_dy;
    s_major  = s_xm ? s_dx : s_dy;
    s_minor2 = s_xm ? s_t2dy : s_t2dx;

    is_last = left_q <= TW'(1);
    d_pos   = ~dterm_q[DW-1];
    step_x  = xm_q | d_pos;
    step_y  = ~xm_q | d_pos;
    add_t   = xm_q ? t2dy_q : t2dx_q;
    sub_t   = d_pos ? (xm_q ? t2dx_q : t2dy_q) : '0;

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    left_d   = left_q;
    dterm_d  = dterm_q;
    t2dx_d   = t2dx_q;
    t2dy_d   = t2dy_q;
    xb_d     = xb_q;
    yb_d     = yb_q;
    xm_d     = xm_q;
    colour_d = colour_q;
    active_d = active_q;

    if (accept_i) begin
      if (op_i == lrpw_pkg::OP_START) begin
        cur_x_d  = x_start_i;
        cur_y_d  = y_start_i;
        t2dx_d   = s_t2dx;
        t2dy_d   = s_t2dy;
        xb_d     = s_xb;
        yb_d     = s_yb;
        xm_d     = s_xm;
        dterm_d  = $signed({1'b0, s_minor2}) - $signed({2'b00, s_major});
        left_d   = {1'b0, s_major} + TW'(1);
        colour_d = colour_i;
        active_d = 1'b1;
      end else if (active_q) begin
        dterm_d = dterm_q + $signed({1'b0, add_t}) - $signed({1'b0, sub_t});
        if (step_x) cur_x_d = xb_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
        if (step_y) cur_y_d = yb_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
        if (is_last) begin
          left_d   = '0;
          active_d = 1'b0;
        end else begin
          left_d = left_q - TW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      left_q   <= '0;
      dterm_q  <= '0;
      t2dx_q   <= '0;
      t2dy_q   <= '0;
      xb_q     <= 1'b0;
      yb_q     <= 1'b0;
      xm_q     <= 1'b0;
      colour_q <= '0;
      active_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      left_q   <= left_d;
      dterm_q  <= dterm_d;
      t2dx_q   <= t2dx_d;
      t2dy_q   <= t2dy_d;
      xb_q     <= xb_d;
      yb_q     <= yb_d;
      xm_q     <= xm_d;
      colour_q <= colour_d;
      active_q <= active_d;
    end
  end

  assign cur_x_o     = cur_x_q;
  assign cur_y_o     = cur_y_q;
  assign colour_o    = colour_q;
  assign ctl_o.active = active_q;
  assign ctl_o.last   = is_last;

endmodule

>>> src/lrpw_pixel_fmt.sv
// Pixel write formatting: byte address, lane-ordered data and byte count.
module lrpw_pixel_fmt #(
  parameter int unsigned COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]             cur_x_i,
  input  logic [COORD_BITS-1:0]             cur_y_i,
  input  logic [lrpw_pkg::COLOUR_BITS-1:0]  colour_i,
  input  logic [lrpw_pkg::BCNT_BITS-1:0]    bpp_i,
  input  logic [lrpw_pkg::PITCH_BITS-1:0]   pitch_i,
  input  logic [lrpw_pkg::ADDR_BITS-1:0]    base_i,
  input  logic                              big_endian_i,
  output logic [lrpw_pkg::ADDR_BITS-1:0]    addr_o,
  output logic [lrpw_pkg::DATA_BITS-1:0]    data_o,
  output logic [lrpw_pkg::BCNT_BITS-1:0]    byte_count_o
);

  localparam int unsigned RW = COORD_BITS + lrpw_pkg::PITCH_BITS;
  localparam int unsigned XW = COORD_BITS + lrpw_pkg::BCNT_BITS;

  logic [lrpw_pkg::BCNT_BITS-1:0] n;
  logic [RW-1:0]                  row_off;
  logic [XW-1:0]                  col_off;
  logic [lrpw_pkg::BCNT_BITS-1:0] src;

  always_comb begin
    // 0 acts as one byte, anything above four as four
    if (bpp_i == '0) begin
      n = lrpw_pkg::BCNT_BITS'(1);
    end else if (bpp_i > lrpw_pkg::BCNT_BITS'(lrpw_pkg::MAX_BYTES)) begin
      n = lrpw_pkg::BCNT_BITS'(lrpw_pkg::MAX_BYTES);
    end else begin
      n = bpp_i;
    end

    row_off = RW'(cur_y_i) * RW'(pitch_i);
    col_off = XW'(cur_x_i) * XW'(n);
    addr_o  = base_i + lrpw_pkg::ADDR_BITS'(row_off) + lrpw_pkg::ADDR_BITS'(col_off);

    data_o = '0;
    for (int i = 0; i < int'(lrpw_pkg::MAX_BYTES); i++) begin
      src = big_endian_i ? (n - lrpw_pkg::BCNT_BITS'(1) - lrpw_pkg::BCNT_BITS'(i))
                         : lrpw_pkg::BCNT_BITS'(i);
      if (lrpw_pkg::BCNT_BITS'(i) < n) begin
        data_o[8*i +: 8] = colour_i[8*src[1:0] +: 8];
      end
    end

    byte_count_o = n;
  end

endmodule

>>> verif/lrpw_pixel_checker.sv
// Checker for the line rasterizer: predicts pixel writes per request and compares the output stream.
`timescale 1ns / 100ps
module lrpw_pixel_checker
  import lrpw_pkg::*;
#(
  parameter int unsigned IN_W  = 80,
  parameter int unsigned OUT_W = 96
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_valid_i,
  input  logic                     s_ready_i,
  input  logic [IN_W-1:0]          s_data_i,
  input  logic                     s_user_i,
  input  logic                     m_valid_i,
  input  logic                     m_ready_i,
  input  logic [OUT_W-1:0]         m_data_i,
  input  logic                     m_last_i,
  output int                       pending_o,
  output int                       fail_count_o
);

  localparam int CB = COORD_BITS_DEF;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
    logic [BCNT_BITS-1:0] bcnt;
    logic [CB-1:0]        px;
    logic [CB-1:0]        py;
    logic                 last;
  } pixel_write_t;

  pixel_write_t writes_due[$];
  int           writes_seen;

  // register copies
  logic [BCNT_BITS-1:0]  bpp_r;
  logic [PITCH_BITS-1:0] pitch_r;
  logic [ADDR_BITS-1:0]  base_r;
  logic                  big_end_r;

  // line state
  logic [CB-1:0]          cur_x, cur_y;
  logic [COLOUR_BITS-1:0] line_colour;
  int                     pixels_left, err_term, twice_dx, twice_dy;
  logic                   x_back, y_back, x_maj, line_on;

  function automatic logic [BCNT_BITS-1:0] pixel_bytes();
    if (bpp_r == 0) return 1;
    if (bpp_r > MAX_BYTES) return MAX_BYTES;
    return bpp_r;
  endfunction

  task automatic rasterize(input op_e op, input logic [IN_W-1:0] td);
    logic [CB-1:0]        x0, y0, x1, y1;
    logic [ADDR_BITS-1:0] ya, pa, xa, na;
    logic [BCNT_BITS-1:0] n;
    int                   dx, dy, src, i;
    pixel_write_t         w;
    if (op == OP_START) begin
      x0 = td[0 +: CB];
      y0 = td[CB +: CB];
      x1 = td[2*CB +: CB];
      y1 = td[3*CB +: CB];
      x_back = x1 < x0;
      y_back = y1 < y0;
      dx = x_back ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
      dy = y_back ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
      twice_dx = 2 * dx;
      twice_dy = 2 * dy;
      x_maj = dx > dy;
      if (x_maj) begin
        err_term    = twice_dy - dx;
        pixels_left = dx + 1;
      end else begin
        err_term    = twice_dx - dy;
        pixels_left = dy + 1;
      end
      cur_x       = x0;
      cur_y       = y0;
      line_colour = td[4*CB +: COLOUR_BITS];
      line_on     = 1'b1;
    end else if (line_on) begin
      n  = pixel_bytes();
      ya = cur_y;
      pa = pitch_r;
      xa = cur_x;
      na = n;
      w.addr = base_r + ya * pa + xa * na;
      w.data = '0;
      for (i = 0; i < n; i++) begin
        src = big_end_r ? int'(n) - 1 - i : i;
        w.data[8*i +: 8] = line_colour[8*src +: 8];
      end
      w.bcnt = n;
      w.px   = cur_x;
      w.py   = cur_y;
      w.last = pixels_left <= 1;
      writes_due.push_back(w);
      // one Bresenham step along the major axis
      if (x_maj) begin
        if (err_term >= 0) begin
          err_term -= twice_dx;
          cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        err_term += twice_dy;
        cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
      end else begin
        if (err_term >= 0) begin
          err_term -= twice_dy;
          cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        err_term += twice_dx;
        cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      if (w.last) begin
        pixels_left = 0;
        line_on     = 1'b0;
      end else begin
        pixels_left--;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: write %0d %s expected 0x%0h got 0x%0h",
               $time, writes_seen, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t want;
    if (!rst_ni) begin
      bpp_r       = BPP_RESET;
      pitch_r     = PITCH_RESET;
      base_r      = BASE_RESET;
      big_end_r   = 1'b0;
      cur_x       = '0;
      cur_y       = '0;
      line_colour = '0;
      pixels_left = 0;
      err_term    = 0;
      twice_dx    = 0;
      twice_dy    = 0;
      x_back      = 1'b0;
      y_back      = 1'b0;
      x_maj       = 1'b0;
      line_on     = 1'b0;
      writes_due.delete();
      writes_seen  = 0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (writes_due.size() == 0) begin
          $display("%0t ns: write %0d expected none got addr 0x%0h",
                   $time, writes_seen, m_data_i[0 +: ADDR_BITS]);
          fail_count_o++;
        end else begin
          want = writes_due.pop_front();
          check_field("pixel_address", want.addr, m_data_i[0 +: ADDR_BITS]);
          check_field("write_data", want.data, m_data_i[ADDR_BITS +: DATA_BITS]);
          check_field("byte_count", want.bcnt, m_data_i[64 +: BCNT_BITS]);
          check_field("pixel_x", want.px, m_data_i[67 +: CB]);
          check_field("pixel_y", want.py, m_data_i[67+CB +: CB]);
          check_field("last", want.last, m_last_i);
        end
        writes_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BYTES_PER_PIXEL: bpp_r     = cfg_data_i[BCNT_BITS-1:0];
          CFG_ROW_PITCH:       pitch_r   = cfg_data_i[PITCH_BITS-1:0];
          CFG_FRAME_BASE:      base_r    = cfg_data_i[ADDR_BITS-1:0];
          CFG_BIG_ENDIAN:      big_end_r = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) rasterize(op_e'(s_user_i), s_data_i);
      pending_o = writes_due.size();
    end
  end

endmodule

>>> verif/line_rasterizer_pixel_writer_tb.sv
// Testbench top for the line rasterizer pixel writer: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module line_rasterizer_pixel_writer_tb;
  import lrpw_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int IN_W        = ((4 * CB + COLOUR_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((ADDR_BITS + DATA_BITS + BCNT_BITS + 2 * CB + 7) / 8) * 8;
  localparam int CMAX        = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 800000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES = 300;     // receiver hold-off for back-pressure
  localparam int ITEM_TARGET = 1200;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_idx_e                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [IN_W-1:0]          s_axis_tdata;
  logic                     m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [OUT_W-1:0]         m_axis_tdata;

  int pending, fail_count;
  int cycle_cnt;

  // flow-control knobs, changed per phase
  int stall_pct, gap_pct;
  bit hold_req;

  // percent chances per phase; phase 0 runs with no idling at all
  int stall_opts[4] = '{0, 10, 35, 70};
  int gap_opts[4]   = '{0, 25, 60, 10};

  line_rasterizer_pixel_writer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lrpw_pixel_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) pixel_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Write receiver. Random stalls, mostly short; on hold_req it keeps tready
  // low for a long fixed stretch so the output register fills and the block
  // has to stall its request input.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Payload of an advance request is ignored by the block; fill it with noise.
  function automatic logic [IN_W-1:0] noise();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[IN_W-1:0];
  endfunction

  function automatic logic [CB-1:0] jitter(input logic [CB-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return v[CB-1:0];
  endfunction

  // Pixels on a line including both endpoints.
  function automatic int pixel_count(input logic [CB-1:0] x0, y0, x1, y1);
    int dx, dy;
    dx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
    dy = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  // Offer one request from a falling edge, hold it until taken, then maybe
  // idle. tvalid is only lowered when a gap follows, so back-to-back
  // requests keep it high.
  task automatic send_req(input op_e op, input logic [IN_W-1:0] payload);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= payload;
    do @(posedge clk); while (!s_axis_tready);
    if ($urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Start a line, then issue adv advance requests. Past the line's end the
  // extra advances are ignored; fewer than the pixel count leaves the line
  // to be dropped by the next start. made counts the requests sent.
  task automatic draw_line(input logic [CB-1:0] x0, y0, x1, y1, input logic [31:0] colour,
                           input int adv, output int made);
    int k;
    send_req(OP_START, {colour, y1, x1, y0, x0});
    for (k = 0; k < adv; k++) send_req(OP_ADVANCE, noise());
    made = 1 + adv;
  endtask

  // Idle the request side and let every write drain, plus slack for an
  // advance that produced nothing but may still be in flight.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_config(input logic [2:0] bpp, input logic [15:0] pitch,
                            input logic [31:0] base, input logic big_end);
    drain();
    cfg_write(CFG_BYTES_PER_PIXEL, bpp);
    cfg_write(CFG_ROW_PITCH, pitch);
    cfg_write(CFG_FRAME_BASE, base);
    cfg_write(CFG_BIG_ENDIAN, big_end);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CB-1:0] x0, y0, x1, y1;
    logic [31:0]   colour, base;
    logic [15:0]   pitch;
    logic [2:0]    bpp;
    logic          big_end;
    int            made, counted, phase, phase_items, n, adv, r, d;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BYTES_PER_PIXEL;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_START;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_pct     = 0;
    gap_pct       = 0;
    hold_req      = 1'b0;
    counted       = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset configuration.
    send_req(OP_ADVANCE, noise());                     // advance with no line
    draw_line(0, 0, 0, 0, 32'hFFFF_FFFF, 2, made);     // single pixel, then ignored advance
    draw_line(CMAX, CMAX, CMAX - 2, CMAX - 5, 32'h1234_5678, 6, made);  // steep, both back
    draw_line(0, CMAX, CMAX, 0, 32'h0, 3, made);       // long diagonal, cut short
    draw_line(CMAX, 0, CMAX - 5, 2, 32'hA5C3_0F96, 6, made);  // restart while active, shallow

    // Random phases. The first four are chosen by hand, mostly at the register
    // extremes; later ones pick settings at random with the edge values weighted in.
    phase = 0;
    while (counted < ITEM_TARGET) begin
      case (phase)
        0: set_config(3'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);  // size 0 acts as 1, wraps
        1: set_config(3'd7, 16'd0, 32'h0, 1'b0);              // size 7 acts as 4
        2: set_config(3'd1, 16'd1, 32'h8000_0000, 1'b1);
        3: set_config(3'd3, 16'd12345, $urandom, 1'b1);
        default: begin
          bpp = $urandom_range(7);
          r   = $urandom_range(99);
          pitch = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(65535));
          r   = $urandom_range(99);
          base = (r < 15) ? 32'h0 : (r < 30) ? 32'hFFFF_FFFF - $urandom_range(255) : $urandom;
          big_end = $urandom_range(1);
          set_config(bpp, pitch, base, big_end);
        end
      endcase
      stall_pct = stall_opts[phase % 4];
      gap_pct   = gap_opts[phase % 4];

      // Full-width line: pixel counter loaded at its largest, dropped early.
      if (phase == 0) draw_line(0, CMAX, CMAX, CMAX - 3, $urandom, 64, made);

      // Back-pressure: receiver holds off while requests keep coming.
      if (phase == 2) begin
        hold_req = 1'b1;
        draw_line(100, 200, 119, 190, $urandom, 20, made);
      end

      phase_items = 0;
      while (phase_items < 100) begin
        x0 = $urandom_range(CMAX);
        y0 = $urandom_range(CMAX);
        r  = $urandom_range(99);
        if (r < 65) begin
          x1 = jitter(x0, 12);
          y1 = jitter(y0, 12);
        end else if (r < 80) begin
          // axis-aligned or exact diagonal
          d = $urandom_range(15);
          case ($urandom_range(2))
            0: begin x1 = x0; y1 = jitter(y0, 20); end
            1: begin y1 = y0; x1 = jitter(x0, 20); end
            default: begin
              x1 = (x0 >= d) ? x0 - d : x0 + d;
              y1 = (int'(y0) + d <= CMAX) ? y0 + d : y0 - d;
            end
          endcase
        end else begin
          x1 = $urandom_range(CMAX);
          y1 = $urandom_range(CMAX);
        end
        r = $urandom_range(9);
        colour = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        n = pixel_count(x0, y0, x1, y1);
        r = $urandom_range(99);
        if (n > 40) adv = $urandom_range(1, 20);              // long line, dropped early
        else if (r < 75) adv = n;
        else if (r < 88) adv = n + $urandom_range(1, 3);      // trailing ignored advances
        else adv = $urandom_range(n);                         // cut short, maybe no pixels
        draw_line(x0, y0, x1, y1, colour, adv, made);
        phase_items += made;
      end
      counted += phase_items;
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
